// File: rtl/ffba_pkg.sv
`timescale 1ns / 1ps
package ffba_pkg;

  typedef enum logic [1:0] {
    KIND_ALLOC     = 2'd0,
    KIND_FREE      = 2'd1,
    KIND_FREE_OWN  = 2'd2,
    KIND_NONE      = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_NOT_START = 2'd2,
    ST_OWNER_0   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_A_RD,
    S_A_CHK,
    S_A_MARK,
    S_F_RD,
    S_F_CHK,
    S_R_WR,
    S_O_RD,
    S_O_CHK,
    S_OUT
  } fsm_t;

  localparam int FIRST_W  = 6;
  localparam int OFFSET_W = 14;
  localparam int COUNT_W  = 7;

endpackage

// File: rtl/first_fit_block_allocator.sv
`timescale 1ns / 1ps
// First-fit contiguous block allocator.
// s_axis carries one request: tuser = kind, tdata = {start_block, owner,
// request_bytes}. m_axis returns one result per request: tuser = status,
// tdata = {block_count, payload_offset, first_block}.
// Allocate scans the block table from block 0 and grants the first run of
// free blocks long enough for payload plus header; free by start block
// releases one allocation; free by owner releases all of one owner.
// All state sits in one entry-per-block RAM (busy, run length, owner) with
// one read port; a scan reads each block's entry in a read state and checks
// it in the check state after it, one block at a time, and the write-back
// then rewrites the granted or released blocks one by one.
// One request is in work at a time. The result sits in an output register
// and s_axis_tready stays low until it is taken, so a stalled receiver
// holds the block.
// After rst a clearing pass writes every entry free;
// no request is accepted during it.
module first_fit_block_allocator #(
  parameter int NUM_BLOCKS   = 64,
  parameter int BLOCK_BYTES  = 256,
  parameter int HEADER_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // request_bytes[15:0], owner[23:16], start_block[29:24]
  input  logic [1:0]  s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // first_block[5:0], payload_offset[19:6], block_count[26:20]
  output logic [1:0]  m_axis_tuser   // status
);
  import ffba_pkg::*;

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam int CW = $clog2(NUM_BLOCKS + 1);
  localparam int EW = 1 + CW + 8;
  localparam int NW = 17 + $clog2(NUM_BLOCKS + 1) + $clog2(BLOCK_BYTES + 1);

  fsm_t state, state_next;

  logic [1:0]  kind;
  logic [15:0] req;
  logic [7:0]  own;

  logic [AW-1:0] idx;        // scan position
  logic          idx_last;
  logic [AW-1:0] wptr;       // write-back position
  logic [CW-1:0] num;        // free run length / blocks left to write
  logic [NW-1:0] cap;        // num * BLOCK_BYTES
  logic [AW-1:0] start;
  logic [CW-1:0] total;
  logic [1:0]    st_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic          e_busy;
  logic [CW-1:0] e_len;
  logic [7:0]    e_own;
  logic [NW-1:0] need;
  logic          fit;

  assign e_busy = rdata[EW-1];
  assign e_len  = rdata[8 +: CW];
  assign e_own  = rdata[7:0];
  assign need   = NW'(req) + NW'(HEADER_BYTES);
  assign idx_last = (idx == AW'(NUM_BLOCKS - 1));
  assign fit    = !e_busy && (need <= cap + NW'(BLOCK_BYTES));

  ffba_ram #(.WIDTH(EW), .DEPTH(NUM_BLOCKS)) u_tbl (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  // result payload
  logic [FIRST_W-1:0]  r_first;
  logic [OFFSET_W-1:0] r_off;
  logic [COUNT_W-1:0]  r_cnt;
  assign m_axis_tdata  = {5'd0, r_cnt, r_off, r_first};
  assign m_axis_tuser  = st_r;
  assign m_axis_tvalid = (state == S_OUT);
  assign s_axis_tready = (state == S_IDLE);
  assign raddr = idx;

  // next state and table writes
  always_comb begin
    state_next = state;
    we    = 1'b0;
    waddr = wptr;
    wdata = '0;
    unique case (state)
      S_CLEAR: begin
        we = 1'b1;
        if (wptr == AW'(NUM_BLOCKS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          unique case (kind_t'(s_axis_tuser))
            KIND_ALLOC:    state_next = S_A_RD;
            KIND_FREE:     state_next = (32'(s_axis_tdata[29:24]) >= NUM_BLOCKS) ?
                                        S_OUT : S_F_RD;
            KIND_FREE_OWN: state_next = (s_axis_tdata[23:16] == 8'd0) ? S_OUT : S_O_RD;
            default:       state_next = S_OUT;
          endcase
        end
      end
      S_A_RD:  state_next = S_A_CHK;
      S_A_CHK: begin
        if (!e_busy && need <= cap + NW'(BLOCK_BYTES)) state_next = S_A_MARK;
        else if (idx_last) state_next = S_OUT;
        else state_next = S_A_RD;
      end
      S_A_MARK: begin
        we = 1'b1;
        wdata = (wptr == start) ? {1'b1, num, own} : {1'b1, CW'(0), 8'd0};
        if (wptr == idx) state_next = S_OUT;
      end
      S_F_RD:  state_next = S_F_CHK;
      S_F_CHK: begin
        if (e_busy && e_len != '0) state_next = S_R_WR;
        else state_next = S_OUT;
      end
      S_R_WR: begin
        if (num != '0 && 32'(wptr) < NUM_BLOCKS) begin
          we = 1'b1;
        end else if (kind == KIND_FREE || idx_last) begin
          state_next = S_OUT;
        end else begin
          state_next = S_O_RD;
        end
      end
      S_O_RD:  state_next = S_O_CHK;
      S_O_CHK: begin
        if (e_busy && e_len != '0 && e_own == own) state_next = S_R_WR;
        else if (idx_last) state_next = S_OUT;
        else state_next = S_O_RD;
      end
      S_OUT: if (m_axis_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
    end else begin
      unique case (state)
        S_CLEAR: wptr <= wptr + AW'(1);
        S_IDLE: if (s_axis_tvalid) begin
          kind <= s_axis_tuser;
          req  <= s_axis_tdata[15:0];
          own  <= s_axis_tdata[23:16];
          idx  <= (kind_t'(s_axis_tuser) == KIND_FREE) ? AW'(s_axis_tdata[29:24]) : '0;
          num  <= '0;
          cap  <= '0;
          total <= '0;
          r_first <= '0;
          r_off   <= '0;
          r_cnt   <= '0;
          unique case (kind_t'(s_axis_tuser))
            KIND_FREE:     st_r <= ST_NOT_START;
            KIND_FREE_OWN: st_r <= (s_axis_tdata[23:16] == 8'd0) ? ST_OWNER_0 : ST_OK;
            KIND_ALLOC:    st_r <= ST_NO_SPACE;
            default:       st_r <= ST_OK;
          endcase
        end
        S_A_CHK: begin
          if (e_busy) begin
            num <= '0;
            cap <= '0;
          end else begin
            num <= num + CW'(1);
            cap <= cap + NW'(BLOCK_BYTES);
            if (need <= cap + NW'(BLOCK_BYTES)) begin
              start <= idx + AW'(1) - AW'(num + CW'(1));
              wptr  <= idx + AW'(1) - AW'(num + CW'(1));
              st_r  <= ST_OK;
              r_first <= FIRST_W'(idx + AW'(1) - AW'(num + CW'(1)));
              r_off   <= OFFSET_W'(32'(idx + AW'(1) - AW'(num + CW'(1))) * BLOCK_BYTES
                                   + HEADER_BYTES);
              r_cnt   <= COUNT_W'(num + CW'(1));
            end
          end
          // hold the scan position on a grant so it marks the run end
          if (!idx_last && !fit) idx <= idx + AW'(1);
        end
        S_A_MARK: wptr <= wptr + AW'(1);
        S_F_CHK: begin
          if (e_busy && e_len != '0) begin
            st_r <= ST_OK;
            num  <= e_len;
            wptr <= idx;
          end
        end
        S_O_CHK: begin
          if (e_busy && e_len != '0 && e_own == own) begin
            num  <= e_len;
            wptr <= idx;
          end else if (!idx_last) begin
            idx <= idx + AW'(1);
          end
        end
        S_R_WR: begin
          if (num != '0 && 32'(wptr) < NUM_BLOCKS) begin
            num   <= num - CW'(1);
            total <= total + CW'(1);
            r_cnt <= COUNT_W'(total + CW'(1));
            if (wptr != AW'(NUM_BLOCKS - 1)) wptr <= wptr + AW'(1);
            else wptr <= wptr;
            if (wptr == AW'(NUM_BLOCKS - 1)) num <= '0;
          end else if (kind != KIND_FREE && !idx_last) begin
            idx <= idx + AW'(1);
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// File: rtl/ffba_ram.sv
`timescale 1ns / 1ps
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/ffba_checker.sv
`timescale 1ns / 1ps
module ffba_assertions (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import ffba_pkg::*;

  // one request in work: never accept while a result waits
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("accept during result");

  // a held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed under stall");

  // non-ok status carries no count
  a_err0: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata[26:20] == 7'd0)
    else $error("error with nonzero count");

  // a grant names at least one block
  a_grant: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ST_OK && m_axis_tdata[19:6] != 14'd0
      |-> m_axis_tdata[26:20] != 7'd0) else $error("empty grant");
endmodule

bind first_fit_block_allocator ffba_assertions u_ffba_assertions (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);
